@@ rtl/core/bshs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bshs_pkg
// Shared constants, request/response payloads and the command/status
// bundles between the lookup controller and its datapath.
// ----------------------------------------------------------------------------
package bshs_pkg;

   // entry array depth and derived widths
   localparam int ENTRY_DEPTH = 1024;
   localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);
   // walk address holds start + count (at most 3070) or any address of the array
   localparam int WALK_W      = (ENTRY_AW + 1 > 12) ? ENTRY_AW + 1 : 12;

   // fixed field widths
   localparam int BUCKETS      = 256;
   localparam int BUCKET_AW    = 8;
   localparam int BUCKET_SHIFT = 24;
   localparam int KEY_W        = 32;
   localparam int POS_W        = 10;
   localparam int FIRST_W      = 10;
   localparam int SIZE_W       = 11;
   localparam int IDX_W        = 10;
   localparam int FUNC_W       = 2;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD_BUCKET = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_ENTRY  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH      = 2'd2;

   // request payload
   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [BUCKET_AW-1:0] bucket_index;
      logic [FIRST_W-1:0]   bucket_first;
      logic [SIZE_W-1:0]    bucket_size;
      logic [IDX_W-1:0]     entry_index;
      logic [KEY_W-1:0]     entry_hash;
      logic [POS_W-1:0]     entry_position;
      logic [KEY_W-1:0]     search_key;
   } bshs_req_type;

   // response payload
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } bshs_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the search key
      logic wr_bucket;  // write bucket descriptor from the request
      logic wr_entry;   // write entry from the request
      logic bkt_rd;     // read descriptor of the key's bucket
      logic walk_init;  // start walk from the descriptor
      logic ent_rd;     // read entry at the walk address
      logic step;       // advance walk by one entry
      logic rsp_load;   // load the response register
      logic rsp_hit;    // response is a hit on the current entry
   } bshs_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic walk_done;  // bucket exhausted or address past the array
      logic hit;        // entry hash equals key
      logic past;       // entry hash above key
   } bshs_stat_type;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_BKT  = 5'b00010,
      ST_CHK  = 5'b00100,
      ST_CMP  = 5'b01000,
      ST_FIN  = 5'b10000
   } bshs_state_type;

endpackage
`default_nettype wire

@@ rtl/core/bshs_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bshs_datapath
// Bucket descriptor table, entry array, walk address/count registers,
// hash comparators and the response register.
// ----------------------------------------------------------------------------
module bshs_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  bshs_pkg::bshs_req_type req_payload,
   input  bshs_pkg::bshs_cmd_type cmd,
   output bshs_pkg::bshs_stat_type stat,
   output bshs_pkg::bshs_rsp_type rsp_payload
);
   import bshs_pkg::*;

   localparam logic [WALK_W-1:0] DEPTH_W = WALK_W'(ENTRY_DEPTH);

   // bucket table: start and count, valid bits give the zero reset value
   logic [FIRST_W+SIZE_W-1:0] bkt_mem_ff [BUCKETS];
   logic [BUCKETS-1:0]        bkt_vld_ff;
   logic [FIRST_W+SIZE_W-1:0] bkt_q_ff;
   logic                      bkt_vld_q_ff;

   // entry array: hash and position
   logic [KEY_W+POS_W-1:0]    ent_mem_ff [ENTRY_DEPTH];
   logic [KEY_W+POS_W-1:0]    ent_q_ff;

   logic [KEY_W-1:0]          key_ff;
   logic [WALK_W-1:0]         addr_ff, addr_in;
   logic [SIZE_W-1:0]         remain_ff, remain_in;
   bshs_rsp_type              rsp_ff, rsp_in;

   logic [BUCKET_AW-1:0]      key_bucket;
   logic [WALK_W-1:0]         ent_wr_ext;
   logic                      ent_wr_ok;
   logic [KEY_W-1:0]          ent_hash;
   logic [POS_W-1:0]          ent_pos;

   assign key_bucket = req_payload.search_key[BUCKET_SHIFT +: BUCKET_AW];
   assign ent_wr_ext = {{(WALK_W-IDX_W){1'b0}}, req_payload.entry_index};
   assign ent_wr_ok  = ent_wr_ext < DEPTH_W;
   assign ent_hash   = ent_q_ff[POS_W +: KEY_W];
   assign ent_pos    = ent_q_ff[POS_W-1:0];

   // bucket table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_bucket) begin
         bkt_mem_ff[req_payload.bucket_index] <=
            {req_payload.bucket_first, req_payload.bucket_size};
      end
      if (cmd.bkt_rd) begin
         bkt_q_ff     <= bkt_mem_ff[key_bucket];
         bkt_vld_q_ff <= bkt_vld_ff[key_bucket];
      end
   end

   // bucket valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         bkt_vld_ff <= '0;
      end else if (cmd.wr_bucket) begin
         bkt_vld_ff[req_payload.bucket_index] <= 1'b1;
      end
   end

   // entry array write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_entry && ent_wr_ok) begin
         ent_mem_ff[ent_wr_ext[ENTRY_AW-1:0]] <=
            {req_payload.entry_hash, req_payload.entry_position};
      end
      if (cmd.ent_rd) begin
         ent_q_ff <= ent_mem_ff[addr_ff[ENTRY_AW-1:0]];
      end
   end

   // search key capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= req_payload.search_key;
      end
   end

   // walk address and remaining count
   always_comb begin
      addr_in   = addr_ff;
      remain_in = remain_ff;
      if (cmd.walk_init) begin
         if (bkt_vld_q_ff) begin
            addr_in   = {{(WALK_W-FIRST_W){1'b0}}, bkt_q_ff[SIZE_W +: FIRST_W]};
            remain_in = bkt_q_ff[SIZE_W-1:0];
         end else begin
            addr_in   = '0;
            remain_in = '0;
         end
      end else if (cmd.step) begin
         addr_in   = addr_ff + WALK_W'(1);
         remain_in = remain_ff - SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      remain_ff <= remain_in;
   end

   // status back to the controller
   assign stat.walk_done = (remain_ff == '0) || (addr_ff >= DEPTH_W);
   assign stat.hit       = ent_hash == key_ff;
   assign stat.past      = ent_hash > key_ff;

   // response register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         if (cmd.rsp_hit) begin
            rsp_in.found    = 1'b1;
            rsp_in.position = ent_pos;
         end else begin
            rsp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/bshs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bshs_ctrl
// Request sequencer: decodes the function, steps the bucket walk and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module bshs_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [bshs_pkg::FUNC_W-1:0]   req_func,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output bshs_pkg::bshs_cmd_type        cmd,
   input  bshs_pkg::bshs_stat_type       stat
);
   import bshs_pkg::*;

   bshs_state_type state_ff, state_in;
   logic           hit_ff, hit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               hit_in      = 1'b0;
               case (req_func)
                  FUNC_LOAD_BUCKET: begin
                     cmd.wr_bucket = 1'b1;
                     state_in      = ST_FIN;
                  end
                  FUNC_LOAD_ENTRY: begin
                     cmd.wr_entry = 1'b1;
                     state_in     = ST_FIN;
                  end
                  FUNC_SEARCH: begin
                     cmd.bkt_rd = 1'b1;
                     state_in   = ST_BKT;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_BKT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_CHK;
         end
         ST_CHK: begin
            if (stat.walk_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.ent_rd = 1'b1;
               state_in   = ST_CMP;
            end
         end
         ST_CMP: begin
            if (stat.hit) begin
               hit_in   = 1'b1;
               state_in = ST_FIN;
            end else if (stat.past) begin
               state_in = ST_FIN;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_hit  = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // a response is never loaded over one still waiting
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over pending response");

   // an accepted request always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start work");

   // a hit response only while the read entry still matches the key
   a_hit_matches: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && cmd.rsp_hit) |-> stat.hit)
      else $error("hit reported without matching entry");
`endif

endmodule
`default_nettype wire

@@ rtl/core/bucketed_sorted_hash_search_top.sv @@
`default_nettype none
// Sequence: a load or an unused code goes from IDLE to FIN; a search goes through
// BKT, then CHK and CMP for each entry read, and to FIN when it stops on an equal
// or greater hash or when the bucket or the array runs out, as checked in CHK.
// A new request is taken only in IDLE, after FIN has loaded the response, and FIN
// waits while a response is still pending; the entry array read port is registered.
// Reset: synchronous; all buckets read as empty at once, entries undefined.
// ----------------------------------------------------------------------------
// bucketed_sorted_hash_search_top
// Hash key lookup engine: bucket descriptors select a sorted run of entries
// that a search walks in order until an equal or greater hash.
// ----------------------------------------------------------------------------
module bucketed_sorted_hash_search_top (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  bshs_pkg::bshs_req_type  req_payload,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output bshs_pkg::bshs_rsp_type  rsp_payload
);
   import bshs_pkg::*;

   bshs_cmd_type  cmd;
   bshs_stat_type stat;

   // sequencer
   bshs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_payload.func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // tables, walk and response register
   bshs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bucketed hash lookup engine. Requests come from
// a queue built up front: a directed opening, then bucket runs (descriptor,
// ascending entries, searches) mixed with random noise. A local lookup model
// predicts every response, and a monitor compares each one field by field.
// ----------------------------------------------------------------------------
module tb;
   import bshs_pkg::*;

   // unused function code, never decoded by the block
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int ITEMS       = 1700;       // requests that do something
   localparam int WALK_CAP    = 64;         // longest walk a search may take
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_AT     = 400;        // responses before the long stall
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_AT    = 900;        // requests before the sender drains
   localparam int TAIL_CYCLES = 200;

   typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} ready_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   bshs_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   bshs_rsp_type rsp_payload;

   // request stream and expected answers
   bshs_req_type request_q[$];
   bshs_rsp_type answer_q[$];
   int           total_requests = 0;
   int           useful_count = 0;
   int           sent_count = 0;
   int           results_seen = 0;
   int           errors = 0;
   int           cycle_count = 0;

   // lookup model state
   logic [FIRST_W-1:0] dir_start [BUCKETS];
   logic [SIZE_W-1:0]  dir_count [BUCKETS];
   logic [KEY_W-1:0]   ent_hash  [ENTRY_DEPTH];
   logic [POS_W-1:0]   ent_pos   [ENTRY_DEPTH];

   // what the generator knows: written slots and bucket runs
   bit plan_written [ENTRY_DEPTH];
   int plan_start   [BUCKETS];
   int plan_count   [BUCKETS];

   // sender and receiver pacing
   int             burst_left = 1;
   int             gap_left = 0;
   bit             drained = 1'b0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left = 0;
   logic [7:0]     ready_pattern = 8'hFF;
   int             hold_left = 0;

   bucketed_sorted_hash_search_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one request to the lookup model and return its response
   function automatic bshs_rsp_type lookup_answer(input bshs_req_type r);
      bshs_rsp_type res;
      int           b;
      int           addr;
      int           left;
      bit           stop;
      res = '0;
      case (r.func)
         FUNC_LOAD_BUCKET: begin
            dir_start[r.bucket_index] = r.bucket_first;
            dir_count[r.bucket_index] = r.bucket_size;
         end
         FUNC_LOAD_ENTRY: begin
            ent_hash[r.entry_index] = r.entry_hash;
            ent_pos[r.entry_index]  = r.entry_position;
         end
         FUNC_SEARCH: begin
            b    = int'(r.search_key >> BUCKET_SHIFT);
            addr = int'(dir_start[b]);
            left = int'(dir_count[b]);
            stop = 1'b0;
            // walk in order until equal, greater, bucket end or array end
            while (left != 0 && addr < ENTRY_DEPTH && !stop) begin
               if (ent_hash[addr] == r.search_key) begin
                  res.found    = 1'b1;
                  res.position = ent_pos[addr];
                  stop = 1'b1;
               end else if (ent_hash[addr] > r.search_key) begin
                  stop = 1'b1;
               end
               addr++;
               left--;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // every field random, other functions' fields included
   function automatic bshs_req_type random_request();
      bshs_req_type r;
      r.func           = FUNC_W'($urandom_range(0, 3));
      r.bucket_index   = BUCKET_AW'($urandom);
      r.bucket_first   = FIRST_W'($urandom);
      r.bucket_size    = SIZE_W'($urandom);
      r.entry_index    = IDX_W'($urandom);
      r.entry_hash     = $urandom;
      r.entry_position = POS_W'($urandom);
      r.search_key     = $urandom;
      return r;
   endfunction

   // a search of this bucket reads only written slots and stays short
   function automatic bit walk_is_safe(input int b);
      int reach;
      reach = plan_count[b];
      if (plan_start[b] + reach > ENTRY_DEPTH) reach = ENTRY_DEPTH - plan_start[b];
      if (reach > WALK_CAP) return 1'b0;
      for (int a = plan_start[b]; a < plan_start[b] + reach; a++) begin
         if (!plan_written[a]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // queue a request, moving unsafe searches to a safe bucket or, failing that, to the unused code
   task automatic queue_request(input bshs_req_type r);
      int b;
      int tries;
      tries = 0;
      if (r.func == FUNC_SEARCH) begin
         b = int'(r.search_key >> BUCKET_SHIFT);
         while (!walk_is_safe(b) && tries < 32) begin
            b = $urandom_range(0, BUCKETS - 1);
            tries++;
         end
         if (walk_is_safe(b)) r.search_key[KEY_W-1 -: BUCKET_AW] = BUCKET_AW'(b);
         else r.func = FUNC_UNUSED;
      end
      case (r.func)
         FUNC_LOAD_BUCKET: begin
            plan_start[r.bucket_index] = int'(r.bucket_first);
            plan_count[r.bucket_index] = int'(r.bucket_size);
         end
         FUNC_LOAD_ENTRY: plan_written[r.entry_index] = 1'b1;
         default: ;
      endcase
      if (r.func != FUNC_UNUSED) useful_count++;
      request_q.push_back(r);
   endtask

   task automatic queue_bucket_load(input int b, input int first, input int size);
      bshs_req_type r;
      r = random_request();
      r.func         = FUNC_LOAD_BUCKET;
      r.bucket_index = BUCKET_AW'(b);
      r.bucket_first = FIRST_W'(first);
      r.bucket_size  = SIZE_W'(size);
      queue_request(r);
   endtask

   task automatic queue_entry_load(input int idx, input logic [KEY_W-1:0] hash,
                                   input int pos);
      bshs_req_type r;
      r = random_request();
      r.func           = FUNC_LOAD_ENTRY;
      r.entry_index    = IDX_W'(idx);
      r.entry_hash     = hash;
      r.entry_position = POS_W'(pos);
      queue_request(r);
   endtask

   task automatic queue_search(input logic [KEY_W-1:0] key);
      bshs_req_type r;
      r = random_request();
      r.func       = FUNC_SEARCH;
      r.search_key = key;
      queue_request(r);
   endtask

   // one bucket: descriptor, ascending run of entries, then searches into it
   task automatic bucket_scenario();
      logic [KEY_W-1:0] run_hash [WALK_CAP];
      logic [KEY_W-1:0] key;
      int b;
      int n;
      int first;
      int size;
      int step_max;
      int low;
      int pick;
      int k;
      int searches;
      b    = $urandom_range(0, BUCKETS - 1);
      pick = $urandom_range(0, 9);
      if (pick == 0) n = 0;
      else if (pick == 1) n = $urandom_range(7, 40);
      else n = $urandom_range(1, 6);
      if (n != 0 && $urandom_range(0, 7) == 0) begin
         // run ends at the top of the array, size may reach far beyond it
         first = ENTRY_DEPTH - n;
         size  = $urandom_range(n, 2047);
      end else begin
         first = $urandom_range(0, ENTRY_DEPTH - 1 - n);
         size  = n;
      end
      queue_bucket_load(b, first, size);
      step_max = 32'h00FF_FFFF / (n + 1);
      low      = $urandom_range(0, step_max);
      for (k = 0; k < n; k++) begin
         run_hash[k] = {BUCKET_AW'(b), BUCKET_SHIFT'(low)};
         queue_entry_load(first + k, run_hash[k], $urandom_range(0, 1023));
         low += $urandom_range(1, step_max);
      end
      searches = $urandom_range(2, 6);
      for (int s = 0; s < searches; s++) begin
         pick = $urandom_range(0, 9);
         if (n == 0 || pick < 3) begin
            key = {BUCKET_AW'(b), BUCKET_SHIFT'($urandom)};
         end else begin
            k = $urandom_range(0, n - 1);
            if (pick < 7) key = run_hash[k];
            else if (pick < 9) key = run_hash[k] + 1;
            else key = run_hash[k] - 1;
         end
         queue_search(key);
      end
   endtask

   // stimulus, reset and end of run
   initial begin : stimulus
      bshs_req_type r;
      // empty buckets straight out of reset
      queue_search(32'h0000_0000);
      queue_search(32'hFFFF_FFFF);
      // unused function code
      r = random_request();
      r.func = FUNC_UNUSED;
      queue_request(r);
      // small bucket: hit, miss on a greater hash, miss at bucket end
      queue_bucket_load(0, 0, 2);
      queue_entry_load(0, 32'h0000_0000, 1023);
      queue_entry_load(1, 32'h0000_0005, 0);
      queue_search(32'h0000_0000);
      queue_search(32'h0000_0003);
      queue_search(32'h0000_0006);
      // oversized bucket running off the end of the array
      queue_bucket_load(255, 1020, 2047);
      queue_entry_load(1020, 32'hFF00_0000, 7);
      queue_entry_load(1021, 32'hFF80_0001, 1023);
      queue_entry_load(1022, 32'hFFFF_FFF0, 0);
      queue_entry_load(1023, 32'hFFFF_FFFE, 512);
      queue_search(32'hFFFF_FFFE);
      queue_search(32'hFFFF_FFFF);
      queue_search(32'hFF00_0000);
      // bucket starting at the last slot
      queue_bucket_load(128, 1023, 1);
      queue_search(32'h8000_0000);
      // bucket emptied again
      queue_bucket_load(0, 0, 0);
      queue_search(32'h0000_0000);

      // random part: mostly well-formed bucket runs, some noise
      while (useful_count < ITEMS) begin
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 4)) queue_request(random_request());
         end else begin
            bucket_scenario();
         end
      end
      total_requests = request_q.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total_requests || answer_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && answer_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // request driver: bursts with gaps, one drain pause
   always @(posedge clock) begin : request_driver
      bshs_req_type next_request;
      bit           offer;
      bit           hold_for_drain;
      if (reset) begin
         req_valid <= 1'b0;
         for (int b = 0; b < BUCKETS; b++) begin
            dir_start[b] = '0;
            dir_count[b] = '0;
         end
      end else begin
         // predict each accepted request in order
         if (req_valid && req_ready) begin
            answer_q.push_back(lookup_answer(req_payload));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            offer = 1'b0;
            hold_for_drain = (sent_count == DRAIN_AT) && !drained;
            if (hold_for_drain && answer_q.size() == 0) begin
               drained = 1'b1;
               hold_for_drain = 1'b0;
            end
            if (!hold_for_drain) begin
               if (gap_left != 0) begin
                  gap_left--;
               end else if (request_q.size() != 0) begin
                  offer = 1'b1;
                  next_request = request_q.pop_front();
                  req_payload <= next_request;
                  burst_left--;
                  if (burst_left == 0) begin
                     burst_left = $urandom_range(1, 24);
                     gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                  end
               end
            end
            req_valid <= offer;
         end
      end
   end

   // response monitor and receiver stall pattern
   always @(posedge clock) begin : response_monitor
      bshs_rsp_type want;
      logic         next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         // compare against the oldest expected answer
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: response with nothing expected: found=%0b position=%0d",
                        $time, rsp_payload.found, rsp_payload.position);
               errors++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_payload.found !== want.found) begin
                  $display("%0t: found mismatch: expected %0b, actual %0b",
                           $time, want.found, rsp_payload.found);
                  errors++;
               end
               if (rsp_payload.position !== want.position) begin
                  $display("%0t: position mismatch: expected %0d, actual %0d",
                           $time, want.position, rsp_payload.position);
                  errors++;
               end
            end
            results_seen++;
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         // switch stall mode now and then
         if (mode_left == 0) begin
            ready_mode    = ready_mode_type'($urandom_range(0, 2));
            mode_left     = $urandom_range(20, 200);
            ready_pattern = 8'($urandom) | 8'h01;
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            case (ready_mode)
               RDY_ALWAYS: next_ready = 1'b1;
               RDY_RANDOM: next_ready = ($urandom_range(0, 2) != 0);
               default: begin
                  next_ready    = ready_pattern[0];
                  ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
               end
            endcase
         end
         rsp_ready <= next_ready;
      end
   end

   // run limit
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
